// ===== rtl/prbc_pkg.sv =====
// shared types and constants of the port bitmap rule clustering unit
// used by the controller, the datapath and the top level
package prbc_pkg;

  localparam int MAX_CLUSTER = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_REDUNDANCY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RULES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GROUP = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_ITER,
    CMD_SCAN,
    CMD_NEXT_REF,
    CMD_HIT,
    CMD_GREEDY_INIT,
    CMD_TAKE,
    CMD_EMIT,
    CMD_REJECT,
    CMD_EMIT_DFLT
  } cmd_e;

  typedef enum logic [2:0] {
    SCAN_REF,
    SCAN_MATCH,
    SCAN_MIN,
    SCAN_CHECK,
    SCAN_DFLT
  } scan_e;

  typedef struct packed {
    cmd_e  cmd;
    scan_e scan;
  } ctrl_t;

  typedef struct packed {
    logic stop;
    logic ref_free;
    logic ref_last;
    logic match_hit;
    logic greedy_done;
    logic fail;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/prbc_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module prbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/prbc_ctrl.sv =====
// sequencer of the clustering unit: load, exact match search, greedy pick,
// check, emit and default rule; depends on prbc_pkg
module prbc_ctrl
  import prbc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_node_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ITER,
    S_REF_CHK,
    S_REF_WAIT,
    S_MATCH_WAIT,
    S_MATCH_END,
    S_GREEDY_RND,
    S_MIN_WAIT,
    S_TAKE,
    S_CHECK_GO,
    S_CHECK_WAIT,
    S_DECIDE,
    S_EMIT,
    S_DFLT_WAIT,
    S_EMIT_DFLT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o.cmd = CMD_NONE;
    ctrl_o.scan = SCAN_REF;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_LOAD;
          if (last_node_i) state_d = S_START;
        end
      end
      S_START: begin
        ctrl_o.cmd = CMD_START;
        state_d = S_ITER;
      end
      S_ITER: begin
        if (status_i.stop) begin
          ctrl_o.cmd = CMD_SCAN;
          ctrl_o.scan = SCAN_DFLT;
          state_d = S_DFLT_WAIT;
        end else begin
          ctrl_o.cmd = CMD_ITER;
          state_d = S_REF_CHK;
        end
      end
      S_REF_CHK: begin
        if (status_i.ref_free) begin
          ctrl_o.cmd = CMD_SCAN;
          ctrl_o.scan = SCAN_REF;
          state_d = S_REF_WAIT;
        end else if (status_i.ref_last) begin
          ctrl_o.cmd = CMD_GREEDY_INIT;
          state_d = S_GREEDY_RND;
        end else begin
          ctrl_o.cmd = CMD_NEXT_REF;
        end
      end
      S_REF_WAIT: begin
        if (status_i.scan_done) begin
          ctrl_o.cmd = CMD_SCAN;
          ctrl_o.scan = SCAN_MATCH;
          state_d = S_MATCH_WAIT;
        end
      end
      S_MATCH_WAIT: begin
        if (status_i.scan_done) state_d = S_MATCH_END;
      end
      S_MATCH_END: begin
        if (status_i.match_hit) begin
          ctrl_o.cmd = CMD_HIT;
          state_d = S_CHECK_GO;
        end else if (status_i.ref_last) begin
          ctrl_o.cmd = CMD_GREEDY_INIT;
          state_d = S_GREEDY_RND;
        end else begin
          ctrl_o.cmd = CMD_NEXT_REF;
          state_d = S_REF_CHK;
        end
      end
      S_GREEDY_RND: begin
        if (status_i.greedy_done) begin
          state_d = S_CHECK_GO;
        end else begin
          ctrl_o.cmd = CMD_SCAN;
          ctrl_o.scan = SCAN_MIN;
          state_d = S_MIN_WAIT;
        end
      end
      S_MIN_WAIT: begin
        if (status_i.scan_done) state_d = S_TAKE;
      end
      S_TAKE: begin
        ctrl_o.cmd = CMD_TAKE;
        state_d = S_GREEDY_RND;
      end
      S_CHECK_GO: begin
        ctrl_o.cmd = CMD_SCAN;
        ctrl_o.scan = SCAN_CHECK;
        state_d = S_CHECK_WAIT;
      end
      S_CHECK_WAIT: begin
        if (status_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.fail) begin
          ctrl_o.cmd = CMD_REJECT;
          state_d = S_ITER;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          ctrl_o.cmd = CMD_EMIT;
          state_d = S_ITER;
        end
      end
      S_DFLT_WAIT: begin
        if (status_i.scan_done) state_d = S_EMIT_DFLT;
      end
      S_EMIT_DFLT: begin
        if (status_i.out_free) begin
          ctrl_o.cmd = CMD_EMIT_DFLT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/prbc_dp.sv =====
// datapath of the clustering unit: bitmap store, store scanner, group,
// union and output registers; depends on prbc_pkg and prbc_ram
module prbc_dp
  import prbc_pkg::*;
#(
  parameter int MAX_NODES = 32,
  parameter int PORT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output status_t               status_o,
  input  logic [31:0]           port_bitmap_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [5:0]            rule_index_o,
  output logic [31:0]           rule_bitmap_o,
  output logic [31:0]           member_slots_o,
  output logic                  default_rule_o,
  output logic                  last_rule_o
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int PCW = $clog2(PORT_BITS + 1);
  localparam int WB = (PORT_BITS > 32) ? PORT_BITS : 32;
  localparam int WM = (MAX_NODES > 32) ? MAX_NODES : 32;

  logic [5:0] limit_q, max_rules_q, max_group_q;
  logic [NW-1:0] node_cnt_q, remain_q;
  logic [MAX_NODES-1:0] assigned_q, members_q, gpool_q, valid_mask, pool;
  logic [5:0] rules_q, k_q, cnt_q, t_q;
  logic [IW-1:0] ref_idx_q, rd_idx_q, proc_idx_q;
  logic [PORT_BITS-1:0] ref_bm_q, union_q, best_val_q, dflt_bm_q, rdata, in_bm, v;
  logic [IW-1:0] best_idx_q;
  logic best_found_q, nofound_q, fail_q;
  logic rd_act_q, proc_vld_q, proc_last_q;
  scan_e mode_q;
  logic out_vld_q, out_dflt_q;
  logic [5:0] out_idx_q;
  logic [PORT_BITS-1:0] out_bm_q;
  logic [MAX_NODES-1:0] out_mem_q;
  logic [WB-1:0] in_ext, out_bm_ext;
  logic [WM-1:0] out_mem_ext;
  logic store_we, out_free;
  logic [PCW-1:0] ham_dist;

  function automatic logic [PCW-1:0] pop(input logic [PORT_BITS-1:0] x);
    logic [PCW-1:0] c;
    c = '0;
    for (int i = 0; i < PORT_BITS; i++) c = c + PCW'(x[i]);
    return c;
  endfunction

  assign in_ext = WB'(port_bitmap_i);
  assign in_bm = in_ext[PORT_BITS-1:0];
  assign store_we = (ctrl_i.cmd == CMD_LOAD) && (node_cnt_q < NW'(MAX_NODES));

  prbc_ram #(.WIDTH(PORT_BITS), .DEPTH(MAX_NODES)) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(node_cnt_q[IW-1:0]),
    .wdata_i(in_bm),
    .re_i   (rd_act_q),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) valid_mask[j] = (NW'(j) < node_cnt_q);
  end
  assign pool = valid_mask & ~assigned_q;
  assign v = rdata | union_q;
  assign ham_dist = pop(rdata ^ union_q);
  assign out_free = !out_vld_q || !out_stall_i;

  assign status_o.stop = (rules_q >= max_rules_q) || (rules_q >= 6'(MAX_CLUSTER)) ||
                         (remain_q == '0);
  assign status_o.ref_free = pool[ref_idx_q];
  assign status_o.ref_last = (ref_idx_q == IW'(MAX_NODES - 1));
  assign status_o.match_hit = (cnt_q == k_q);
  assign status_o.greedy_done = (t_q == k_q) || nofound_q;
  assign status_o.fail = fail_q;
  assign status_o.scan_done = proc_vld_q && proc_last_q;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd2;
      max_rules_q <= 6'd32;
      max_group_q <= 6'd32;
      node_cnt_q <= '0;
      assigned_q <= '0;
      rules_q <= '0;
      k_q <= '0;
      remain_q <= '0;
      rd_act_q <= 1'b0;
      proc_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REDUNDANCY_LIMIT: limit_q <= cfg_data_i;
          REG_MAX_RULES: max_rules_q <= cfg_data_i;
          REG_MAX_GROUP: max_group_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (rd_act_q) begin
        rd_idx_q <= rd_idx_q + IW'(1);
        if (rd_idx_q == IW'(MAX_NODES - 1)) rd_act_q <= 1'b0;
      end
      proc_vld_q <= rd_act_q;
      proc_idx_q <= rd_idx_q;
      proc_last_q <= (rd_idx_q == IW'(MAX_NODES - 1));
      if (!out_stall_i && ctrl_i.cmd != CMD_EMIT && ctrl_i.cmd != CMD_EMIT_DFLT) begin
        out_vld_q <= 1'b0;
      end

      if (proc_vld_q) begin
        unique case (mode_q)
          SCAN_REF: if (proc_idx_q == ref_idx_q) ref_bm_q <= rdata;
          SCAN_MATCH: begin
            if (pool[proc_idx_q] && (rdata == ref_bm_q) && (cnt_q < k_q)) begin
              members_q[proc_idx_q] <= 1'b1;
              cnt_q <= cnt_q + 6'd1;
            end
          end
          SCAN_MIN: begin
            if (gpool_q[proc_idx_q] && (!best_found_q || (v < best_val_q))) begin
              best_found_q <= 1'b1;
              best_idx_q <= proc_idx_q;
              best_val_q <= v;
            end
          end
          SCAN_CHECK: begin
            if (members_q[proc_idx_q] && ({2'b0, ham_dist} > {2'b0, limit_q})) fail_q <= 1'b1;
          end
          SCAN_DFLT: if (pool[proc_idx_q]) dflt_bm_q <= dflt_bm_q | rdata;
          default: ;
        endcase
      end

      unique case (ctrl_i.cmd)
        CMD_LOAD: if (store_we) node_cnt_q <= node_cnt_q + NW'(1);
        CMD_START: begin
          assigned_q <= '0;
          rules_q <= '0;
          k_q <= (max_group_q == '0) ? 6'd1 : max_group_q;
          remain_q <= node_cnt_q;
        end
        CMD_ITER: begin
          if ({2'b0, k_q} > 8'(remain_q)) k_q <= 6'(remain_q);
          else if (k_q == '0) k_q <= 6'd1;
          ref_idx_q <= '0;
        end
        CMD_SCAN: begin
          rd_act_q <= 1'b1;
          rd_idx_q <= '0;
          mode_q <= ctrl_i.scan;
          unique case (ctrl_i.scan)
            SCAN_MATCH: begin
              members_q <= '0;
              cnt_q <= '0;
            end
            SCAN_MIN: best_found_q <= 1'b0;
            SCAN_CHECK: fail_q <= 1'b0;
            SCAN_DFLT: dflt_bm_q <= '0;
            default: ;
          endcase
        end
        CMD_NEXT_REF: ref_idx_q <= ref_idx_q + IW'(1);
        CMD_HIT: union_q <= ref_bm_q;
        CMD_GREEDY_INIT: begin
          gpool_q <= pool;
          members_q <= '0;
          union_q <= '0;
          t_q <= '0;
          nofound_q <= 1'b0;
        end
        CMD_TAKE: begin
          if (best_found_q) begin
            gpool_q[best_idx_q] <= 1'b0;
            members_q[best_idx_q] <= 1'b1;
            union_q <= best_val_q;
            t_q <= t_q + 6'd1;
          end else begin
            nofound_q <= 1'b1;
          end
        end
        CMD_EMIT: begin
          out_vld_q <= 1'b1;
          out_idx_q <= rules_q;
          out_bm_q <= union_q;
          out_mem_q <= members_q;
          out_dflt_q <= 1'b0;
          assigned_q <= assigned_q | members_q;
          rules_q <= rules_q + 6'd1;
          remain_q <= remain_q - NW'(k_q);
        end
        CMD_REJECT: k_q <= k_q - 6'd1;
        CMD_EMIT_DFLT: begin
          out_vld_q <= 1'b1;
          out_idx_q <= rules_q;
          out_bm_q <= dflt_bm_q;
          out_mem_q <= pool;
          out_dflt_q <= 1'b1;
          node_cnt_q <= '0;
          assigned_q <= '0;
          remain_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_bm_ext = WB'(out_bm_q);
  assign out_mem_ext = WM'(out_mem_q);
  assign out_valid_o = out_vld_q;
  assign rule_index_o = out_idx_q;
  assign rule_bitmap_o = out_bm_ext[31:0];
  assign member_slots_o = out_mem_ext[31:0];
  assign default_rule_o = out_dflt_q;
  assign last_rule_o = out_dflt_q;

`ifndef SYNTHESIS
  a_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == CMD_SCAN) |-> !rd_act_q)
    else $error("scan started while store reads still pending");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == CMD_EMIT || ctrl_i.cmd == CMD_EMIT_DFLT) |-> !(out_vld_q && out_stall_i))
    else $error("result overwritten while stalled");
  a_assigned_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (assigned_q & ~valid_mask) == '0)
    else $error("assigned node outside loaded set");
  a_remain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q <= node_cnt_q)
    else $error("remaining count above node count");
`endif

endmodule

// ===== rtl/port_bitmap_rule_clustering_unit.sv =====
// top level of the port bitmap rule clustering unit
// depends on prbc_pkg, prbc_ctrl and prbc_dp
//
//  channel | handshake               | payload
//  input   | in_valid_i / in_stall_o   | port_bitmap_i, last_node_i
//  output  | out_valid_o / out_stall_i | rule_index_o, rule_bitmap_o, member_slots_o,
//          |                           | default_rule_o, last_rule_o
//  config  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// loading takes one word per cycle while no run is active
// a run walks the store once per scan through one read port:
// exact search costs up to 2 walks per free node, the greedy pick one walk
// per member, the check and the default rule one walk each
// a result waits in the output register; the run holds while it is stalled
// reset leaves the store undefined and clears the node, rule and remaining counts and the assigned mask
module port_bitmap_rule_clustering_unit
  import prbc_pkg::*;
#(
  parameter int MAX_NODES = 32,
  parameter int PORT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           port_bitmap_i,
  input  logic                  last_node_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [5:0]            rule_index_o,
  output logic [31:0]           rule_bitmap_o,
  output logic [31:0]           member_slots_o,
  output logic                  default_rule_o,
  output logic                  last_rule_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_t   ctrl;
  status_t status;

  prbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_node_i(last_node_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  prbc_dp #(.MAX_NODES(MAX_NODES), .PORT_BITS(PORT_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .port_bitmap_i (port_bitmap_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rule_index_o  (rule_index_o),
    .rule_bitmap_o (rule_bitmap_o),
    .member_slots_o(member_slots_o),
    .default_rule_o(default_rule_o),
    .last_rule_o   (last_rule_o)
  );

endmodule
